// ===== design/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation: shared types and helpers
// Q2.30 constants, register indexes, stage payload types and the
// rounding and clamping helpers used by the rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

  localparam int DATA_W = 32;
  localparam int TOL_W = 30;
  localparam int CFG_IDX_W = 3;

  // Integer square root of a 64-bit sum: one result bit a stage
  localparam int SQRT_STEPS = 32;
  // Quotient bits of the normalising division (quotient never exceeds 2^30)
  localparam int DIV_STEPS = 31;

  localparam logic signed [DATA_W-1:0] Q30_ONE = 32'sh4000_0000;
  localparam logic signed [DATA_W-1:0] Q30_MINUS_ONE = -32'sh4000_0000;
  localparam logic signed [63:0] RND_HALF = 64'sh2000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUAT_SCALAR = 3'd0,
    REG_QUAT_X = 3'd1,
    REG_QUAT_Y = 3'd2,
    REG_QUAT_Z = 3'd3,
    REG_UNIT_TOL = 3'd4
  } cfg_reg_t;

  // Rotated vector before magnitude correction
  typedef struct packed {
    logic [2:0][DATA_W-1:0] r;
    logic [63:0] m;
    logic renorm;
  } front_t;

  typedef struct packed {
    logic [DATA_W-1:0] rot_x;
    logic [DATA_W-1:0] rot_y;
    logic [DATA_W-1:0] rot_z;
    logic renormalised;
  } res_t;

  // Clamp to [-1.0, +1.0]
  function automatic logic signed [DATA_W-1:0] clamp_unit(input logic signed [DATA_W-1:0] v);
    logic signed [DATA_W-1:0] o;
    if (v > Q30_ONE) begin
      o = Q30_ONE;
    end else if (v < Q30_MINUS_ONE) begin
      o = Q30_MINUS_ONE;
    end else begin
      o = v;
    end
    return o;
  endfunction

  // Q.60 to Q.30, round half towards plus infinity; |x| < 2^62
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + RND_HALF;
    return signed'(t[63:30]);
  endfunction

endpackage

`default_nettype wire

// ===== design/qvr_if.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation: channel interfaces
// Valid/ready channels for input vectors, rotated results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface qvr_vec_if;
  logic valid;
  logic ready;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

interface qvr_rot_if;
  logic valid;
  logic ready;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;
  logic renormalised;

  modport source (output valid, output rot_x, output rot_y, output rot_z,
                  output renormalised, input ready);
  modport sink (input valid, input rot_x, input rot_y, input rot_z,
                input renormalised, output ready);
endinterface

interface qvr_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/qvr_renorm.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation: magnitude correction
// Pipelined integer square root, three pipelined dividers and the final
// select between the corrected and the clamped vector.
// ----------------------------------------------------------------------------
`default_nettype none

module qvr_renorm (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire qvr_pkg::front_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output qvr_pkg::res_t out_data
);

  localparam int SQ = qvr_pkg::SQRT_STEPS;
  localparam int DV = qvr_pkg::DIV_STEPS;
  localparam int PREP = SQ;
  localparam int DIV0 = SQ + 1;
  localparam int OUTS = SQ + 1 + DV;
  localparam int NST = OUTS + 1;

  typedef struct packed {
    logic [2:0][31:0] r;
    logic renorm;
  } side_t;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;
  logic [NST-1:0] vld_prev;

  // Per-stage advance: a stage loads when empty or when its word moves on
  genvar gi;
  for (gi = 0; gi < NST; gi++) begin : g_en
    if (gi == NST - 1) begin : g_last
      assign en[gi] = !vld[gi] || out_ready;
    end else begin : g_mid
      assign en[gi] = !vld[gi] || en[gi+1];
    end
  end

  assign vld_prev = {vld[NST-2:0], in_valid};
  assign in_ready = en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld_prev[i];
        end
      end
    end
  end

  // ---- square root ----
  logic [SQ-1:0][63:0] sq_rem;
  logic [SQ-1:0][63:0] sq_res;
  side_t [SQ-1:0] sq_side;
  logic [SQ-1:0][63:0] rem_prev;
  logic [SQ-1:0][63:0] res_prev;
  side_t [SQ-1:0] side_prev;

  always_comb begin
    rem_prev[0] = in_data.m;
    res_prev[0] = '0;
    side_prev[0].r = in_data.r;
    side_prev[0].renorm = in_data.renorm;
    for (int i = 1; i < SQ; i++) begin
      rem_prev[i] = sq_rem[i-1];
      res_prev[i] = sq_res[i-1];
      side_prev[i] = sq_side[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SQ; i++) begin
      if (en[i]) begin
        if (rem_prev[i] >= res_prev[i] + (64'd1 << (62 - 2 * i))) begin
          sq_rem[i] <= rem_prev[i] - (res_prev[i] + (64'd1 << (62 - 2 * i)));
          sq_res[i] <= (res_prev[i] >> 1) + (64'd1 << (62 - 2 * i));
        end else begin
          sq_rem[i] <= rem_prev[i];
          sq_res[i] <= res_prev[i] >> 1;
        end
        sq_side[i] <= side_prev[i];
      end
    end
  end

  // ---- divide: index 0 is the set-up stage ----
  logic [DV:0][31:0] dv_root;
  logic [DV:0][2:0][31:0] dv_rem;
  logic [DV:0][2:0][30:0] dv_low;
  logic [DV:0][2:0][30:0] dv_q;
  logic [DV:0][2:0] dv_neg;
  side_t [DV:0] dv_side;

  logic [31:0] root0;
  logic [2:0][31:0] mag0;
  logic [2:0][62:0] num0;

  always_comb begin
    root0 = sq_res[SQ-1][31:0];
    for (int l = 0; l < 3; l++) begin
      mag0[l] = sq_side[SQ-1].r[l][31] ? 32'(-sq_side[SQ-1].r[l]) : sq_side[SQ-1].r[l];
      num0[l] = {1'b0, mag0[l], 30'b0} + {32'b0, root0[31:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[PREP]) begin
      dv_root[0] <= root0;
      dv_side[0] <= sq_side[SQ-1];
      for (int l = 0; l < 3; l++) begin
        dv_rem[0][l] <= num0[l][62:31];
        dv_low[0][l] <= num0[l][30:0];
        dv_q[0][l] <= '0;
        dv_neg[0][l] <= sq_side[SQ-1].r[l][31];
      end
    end
  end

  logic [DV-1:0][2:0][32:0] dv_trial;
  logic [DV-1:0][2:0] dv_ge;

  always_comb begin
    for (int j = 0; j < DV; j++) begin
      for (int l = 0; l < 3; l++) begin
        dv_trial[j][l] = {dv_rem[j][l], dv_low[j][l][30]};
        dv_ge[j][l] = dv_trial[j][l] >= {1'b0, dv_root[j]};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DV; j++) begin
      if (en[DIV0+j]) begin
        dv_root[j+1] <= dv_root[j];
        dv_side[j+1] <= dv_side[j];
        dv_neg[j+1] <= dv_neg[j];
        for (int l = 0; l < 3; l++) begin
          dv_rem[j+1][l] <= dv_ge[j][l] ? 32'(dv_trial[j][l] - {1'b0, dv_root[j]})
                                        : dv_trial[j][l][31:0];
          dv_low[j+1][l] <= {dv_low[j][l][29:0], 1'b0};
          dv_q[j+1][l] <= {dv_q[j][l][29:0], dv_ge[j][l]};
        end
      end
    end
  end

  // ---- result select ----
  logic [2:0][31:0] rot;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_side[DV].renorm) begin
        rot[l] = dv_neg[DV][l] ? 32'(-{1'b0, dv_q[DV][l]}) : {1'b0, dv_q[DV][l]};
      end else begin
        rot[l] = qvr_pkg::clamp_unit(signed'(dv_side[DV].r[l]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUTS]) begin
      out_data.rot_x <= rot[0];
      out_data.rot_y <= rot[1];
      out_data.rot_z <= rot[2];
      out_data.renormalised <= dv_side[DV].renorm;
    end
  end

endmodule

`default_nettype wire

// ===== design/quaternion_vector_rotation.sv =====
// ----------------------------------------------------------------------------
// Quaternion vector rotation
// Rotates a stream of Q2.30 vectors by a configured unit quaternion.
// ----------------------------------------------------------------------------
// The block takes one vector word per clock while the output side keeps up
// and returns one rotated word per input word, in order, through eight
// arithmetic stages (operand clamp, products, rounding, d*q, sum and
// saturate, squares, magnitude, tolerance test) followed by 32 square-root
// stages, one divider set-up stage, 31 divider stages and the output register.
// Every stage holds its own valid bit and loads whenever it is empty or its
// word moves on, so bubbles close up and input is taken while a finished word
// waits at the output. Writes to the register channel are always taken, as
// ready is held high; write only while no vector is in flight. Indexes beyond
// the register list are dropped. No clearing pass follows reset.
`default_nettype none

module quaternion_vector_rotation (
  input  wire logic clk,
  input  wire logic rst,
  qvr_vec_if.sink vec_in,
  qvr_rot_if.source rot_out,
  qvr_cfg_if.sink cfg
);

  // ---- configuration registers ----
  logic [31:0] cfg_s;
  logic [2:0][31:0] cfg_q;
  logic [qvr_pkg::TOL_W-1:0] cfg_tol;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_s <= 32'h4000_0000;
      cfg_q <= '0;
      cfg_tol <= 30'd64;
    end else if (cfg.valid) begin
      unique case (qvr_pkg::cfg_reg_t'(cfg.index))
        qvr_pkg::REG_QUAT_SCALAR: cfg_s <= cfg.data;
        qvr_pkg::REG_QUAT_X: cfg_q[0] <= cfg.data;
        qvr_pkg::REG_QUAT_Y: cfg_q[1] <= cfg.data;
        qvr_pkg::REG_QUAT_Z: cfg_q[2] <= cfg.data;
        qvr_pkg::REG_UNIT_TOL: cfg_tol <= cfg.data[qvr_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- coefficients: recomputed every cycle from the registers ----
  logic signed [31:0] s_c;
  logic signed [31:0] q_c [3];
  logic signed [63:0] ss_full;
  logic signed [63:0] sq_full [3];
  logic signed [33:0] k_w;
  logic signed [33:0] p_w [3];

  logic signed [31:0] co_k;
  logic signed [31:0] co_p [3];
  logic signed [31:0] co_q [3];

  always_comb begin
    s_c = qvr_pkg::clamp_unit(signed'(cfg_s));
    ss_full = s_c * s_c;
    k_w = (qvr_pkg::rnd30(ss_full) <<< 1) - 34'sh4000_0000;
    for (int i = 0; i < 3; i++) begin
      q_c[i] = qvr_pkg::clamp_unit(signed'(cfg_q[i]));
      sq_full[i] = s_c * q_c[i];
      p_w[i] = qvr_pkg::rnd30(sq_full[i]);
    end
  end

  always_ff @(posedge clk) begin
    co_k <= k_w[31:0];
    for (int i = 0; i < 3; i++) begin
      co_p[i] <= p_w[i][31:0];
      co_q[i] <= q_c[i];
    end
  end

  // ---- front pipeline control ----
  localparam int NF = 8;
  logic [NF-1:0] vld_f;
  logic [NF-1:0] en_f;
  logic ren_ready;

  // Advance a stage when it is empty or its word moves on
  genvar gi;
  for (gi = 0; gi < NF; gi++) begin : g_en
    if (gi == NF - 1) begin : g_last
      assign en_f[gi] = !vld_f[gi] || ren_ready;
    end else begin : g_mid
      assign en_f[gi] = !vld_f[gi] || en_f[gi+1];
    end
  end

  assign vec_in.ready = en_f[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_f <= '0;
    end else begin
      for (int i = 0; i < NF; i++) begin
        if (en_f[i]) begin
          vld_f[i] <= (i == 0) ? vec_in.valid : vld_f[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // Stage 1: clamp operands
  logic signed [31:0] v1 [3];

  always_ff @(posedge clk) begin
    if (en_f[0]) begin
      v1[0] <= qvr_pkg::clamp_unit(vec_in.vec_x);
      v1[1] <= qvr_pkg::clamp_unit(vec_in.vec_y);
      v1[2] <= qvr_pkg::clamp_unit(vec_in.vec_z);
    end
  end

  // Stage 2: all products with v; cross terms in pairs (a - b)
  logic signed [63:0] pc2 [6];
  logic signed [63:0] pd2 [3];
  logic signed [63:0] pk2 [3];

  always_ff @(posedge clk) begin
    if (en_f[1]) begin
      pc2[0] <= co_p[1] * v1[2];
      pc2[1] <= co_p[2] * v1[1];
      pc2[2] <= co_p[2] * v1[0];
      pc2[3] <= co_p[0] * v1[2];
      pc2[4] <= co_p[0] * v1[1];
      pc2[5] <= co_p[1] * v1[0];
      for (int i = 0; i < 3; i++) begin
        pd2[i] <= co_q[i] * v1[i];
        pk2[i] <= co_k * v1[i];
      end
    end
  end

  // Stage 3: round cross product, dot product and scaled vector
  logic signed [33:0] c3 [3];
  logic signed [33:0] kv3 [3];
  logic signed [33:0] d3;

  always_ff @(posedge clk) begin
    if (en_f[2]) begin
      d3 <= qvr_pkg::rnd30(pd2[0] + pd2[1] + pd2[2]);
      for (int i = 0; i < 3; i++) begin
        c3[i] <= qvr_pkg::rnd30(pc2[2*i] - pc2[2*i+1]);
        kv3[i] <= qvr_pkg::rnd30(pk2[i]);
      end
    end
  end

  // Stage 4: d * q
  logic signed [65:0] dq_full [3];
  logic signed [63:0] dq4 [3];
  logic signed [33:0] c4 [3];
  logic signed [33:0] kv4 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dq_full[i] = d3 * co_q[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en_f[3]) begin
      for (int i = 0; i < 3; i++) begin
        dq4[i] <= signed'(dq_full[i][63:0]);
        c4[i] <= c3[i];
        kv4[i] <= kv3[i];
      end
    end
  end

  // Stage 5: combine and saturate to the 32-bit range
  logic signed [36:0] rw5 [3];
  logic signed [31:0] r5 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rw5[i] = 37'(kv4[i]) + ((37'(c4[i]) + 37'(qvr_pkg::rnd30(dq4[i]))) <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en_f[4]) begin
      for (int i = 0; i < 3; i++) begin
        if (rw5[i] > 37'sh0_7FFF_FFFF) begin
          r5[i] <= 32'sh7FFF_FFFF;
        end else if (rw5[i] < -37'sh0_8000_0000) begin
          r5[i] <= 32'sh8000_0000;
        end else begin
          r5[i] <= signed'(rw5[i][31:0]);
        end
      end
    end
  end

  // Stage 6: squares
  logic signed [63:0] sqr6 [3];
  logic signed [31:0] r6 [3];

  always_ff @(posedge clk) begin
    if (en_f[5]) begin
      for (int i = 0; i < 3; i++) begin
        sqr6[i] <= r5[i] * r5[i];
        r6[i] <= r5[i];
      end
    end
  end

  // Stage 7: squared magnitude, exact in Q.60
  logic [63:0] m7;
  logic signed [31:0] r7 [3];

  always_ff @(posedge clk) begin
    if (en_f[6]) begin
      m7 <= unsigned'(sqr6[0]) + unsigned'(sqr6[1]) + unsigned'(sqr6[2]);
      for (int i = 0; i < 3; i++) begin
        r7[i] <= r6[i];
      end
    end
  end

  // Stage 8: tolerance test; a zero vector is never corrected
  logic [64:0] ms8;
  logic signed [35:0] dev8;
  logic [35:0] adev8;
  qvr_pkg::front_t f8;

  always_comb begin
    ms8 = {1'b0, m7} + 65'h2000_0000;
    dev8 = signed'({1'b0, ms8[64:30]}) - 36'sh4000_0000;
    adev8 = dev8[35] ? 36'(-dev8) : dev8;
  end

  always_ff @(posedge clk) begin
    if (en_f[7]) begin
      f8.m <= m7;
      f8.renorm <= (adev8 > {6'b0, cfg_tol}) && (m7 != '0);
      for (int i = 0; i < 3; i++) begin
        f8.r[i] <= r7[i];
      end
    end
  end

  // ---- correction pipeline and output register ----
  qvr_pkg::res_t res;

  qvr_renorm u_renorm (
    .clk(clk),
    .rst(rst),
    .in_valid(vld_f[NF-1]),
    .in_ready(ren_ready),
    .in_data(f8),
    .out_valid(rot_out.valid),
    .out_ready(rot_out.ready),
    .out_data(res)
  );

  assign rot_out.rot_x = res.rot_x;
  assign rot_out.rot_y = res.rot_y;
  assign rot_out.rot_z = res.rot_z;
  assign rot_out.renormalised = res.renormalised;

endmodule

`default_nettype wire
